[src/lsp_pkg.sv]
`default_nettype none

package lsp_pkg;

    // Command codes carried in the input tuser field.
    localparam logic [1:0] CMD_SPAWN = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam int CMD_W       = 2;
    localparam int TICKS_W     = 16;
    localparam int SLOT_OUT_W  = 6;
    localparam int COUNT_OUT_W = 7;

    // One accepted command with its operands.
    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [TICKS_W-1:0] life_ticks;
        logic [TICKS_W-1:0] elapsed_ticks;
    } lsp_cmd_t;

    // One result item as it leaves the sequencer.
    typedef struct packed {
        logic [SLOT_OUT_W-1:0]  slot_index;
        logic                   evicted;
        logic [COUNT_OUT_W-1:0] expired_count;
        logic [COUNT_OUT_W-1:0] active_total;
    } lsp_res_t;

endpackage

`default_nettype wire

[src/lsp_ram.sv]
`default_nettype none

module lsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[src/lsp_seq.sv]
`default_nettype none

module lsp_seq
    import lsp_pkg::*;
#(
    parameter int SLOTS     = 64,
    parameter int LIFE_BITS = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cmd_valid,
    output logic                                        cmd_ready,
    input  wire lsp_cmd_t                               cmd,
    output logic                                        res_valid,
    input  wire logic                                   res_ready,
    output lsp_res_t                                    res,
    output logic                                        slot_we,
    output logic [$clog2(SLOTS)-1:0]                    slot_waddr,
    output logic [$clog2(SLOTS)+LIFE_BITS-1:0]          slot_wdata,
    output logic [$clog2(SLOTS)-1:0]                    slot_raddr,
    input  wire logic [$clog2(SLOTS)+LIFE_BITS-1:0]     slot_rdata,
    output logic                                        list_we,
    output logic [$clog2(SLOTS)-1:0]                    list_waddr,
    output logic [$clog2(SLOTS)-1:0]                    list_wdata,
    output logic [$clog2(SLOTS)-1:0]                    list_raddr,
    input  wire logic [$clog2(SLOTS)-1:0]               list_rdata
);

    localparam int AW   = $clog2(SLOTS);
    localparam int CNTW = $clog2(SLOTS + 1);
    localparam int CMPW = (LIFE_BITS > TICKS_W) ? LIFE_BITS : TICKS_W;
    localparam logic [AW-1:0]   LAST_SLOT = AW'(SLOTS - 1);
    localparam logic [CNTW-1:0] FULL      = CNTW'(SLOTS);

    typedef enum logic [3:0] {
        IDLE, SC_POS, SC_LIST, EV_HEAD, EV_LAST, EV_RMW, EV_APP,
        TK_LIST, TK_SLOT, TK_LAST, TK_MOVE, TK_NEXT, DONE
    } state_t;

    state_t               state_reg;
    logic [CNTW-1:0]      count_reg;
    logic [AW-1:0]        start_reg;
    logic [AW-1:0]        cur_reg;
    logic [AW-1:0]        last_reg;
    logic [AW-1:0]        idx_reg;
    logic [CNTW-1:0]      expired_reg;
    logic [LIFE_BITS-1:0] life_reg;
    logic [TICKS_W-1:0]   elapsed_reg;
    logic [AW-1:0]        slot_out_reg;
    logic                 evict_reg;

    logic [AW-1:0]        rd_pos;
    logic [LIFE_BITS-1:0] rd_life;
    logic                 pos_free;
    logic                 list_hit;
    logic                 expire;
    logic [LIFE_BITS-1:0] life_dec;
    logic [CNTW-1:0]      count_m1;
    logic [AW-1:0]        tail_addr;
    logic [CNTW-1:0]      idx_p1;
    logic [AW-1:0]        cur_succ;
    logic [CMPW-1:0]      life_in_ext;
    logic [CMPW-1:0]      life_max_ext;
    logic [LIFE_BITS-1:0] life_sat;

    assign rd_pos    = slot_rdata[AW+LIFE_BITS-1:LIFE_BITS];
    assign rd_life   = slot_rdata[LIFE_BITS-1:0];
    // A slot is free unless its stored position points back at it inside the list.
    assign pos_free  = CNTW'(rd_pos) >= count_reg;
    assign list_hit  = list_rdata == cur_reg;
    assign expire    = CMPW'(rd_life) <= CMPW'(elapsed_reg);
    assign life_dec  = LIFE_BITS'(CMPW'(rd_life) - CMPW'(elapsed_reg));
    assign count_m1  = count_reg - 1'b1;
    assign tail_addr = count_m1[AW-1:0];
    assign idx_p1    = CNTW'(idx_reg) + 1'b1;
    assign cur_succ  = (cur_reg == LAST_SLOT) ? '0 : cur_reg + 1'b1;

    assign life_in_ext  = CMPW'(cmd.life_ticks);
    assign life_max_ext = CMPW'({LIFE_BITS{1'b1}});
    assign life_sat     = LIFE_BITS'((life_in_ext > life_max_ext) ? life_max_ext : life_in_ext);

    assign cmd_ready = state_reg == IDLE;
    assign res_valid = state_reg == DONE;

    assign res.slot_index    = SLOT_OUT_W'(slot_out_reg);
    assign res.evicted       = evict_reg;
    assign res.expired_count = COUNT_OUT_W'(expired_reg);
    assign res.active_total  = COUNT_OUT_W'(count_reg);

    // Memory port control.
    always_comb
    begin
        slot_we    = 1'b0;
        slot_waddr = cur_reg;
        slot_wdata = {AW'(count_reg), life_reg};
        slot_raddr = cur_reg;
        list_we    = 1'b0;
        list_waddr = AW'(count_reg);
        list_wdata = cur_reg;
        list_raddr = '0;
        case (state_reg)
            IDLE:
            begin
                slot_raddr = start_reg;
            end
            SC_POS:
            begin
                if (pos_free)
                begin
                    slot_we = 1'b1;
                    list_we = 1'b1;
                end
                else
                begin
                    list_raddr = rd_pos;
                end
            end
            SC_LIST:
            begin
                if (list_hit)
                begin
                    slot_raddr = cur_succ;
                end
                else
                begin
                    slot_we = 1'b1;
                    list_we = 1'b1;
                end
            end
            EV_HEAD:
            begin
                list_raddr = tail_addr;
            end
            EV_LAST:
            begin
                slot_raddr = list_rdata;
            end
            EV_RMW:
            begin
                slot_we    = 1'b1;
                slot_waddr = last_reg;
                slot_wdata = {AW'(0), rd_life};
                list_we    = 1'b1;
                list_waddr = '0;
                list_wdata = last_reg;
            end
            EV_APP:
            begin
                slot_we    = 1'b1;
                slot_wdata = {tail_addr, life_reg};
                list_we    = 1'b1;
                list_waddr = tail_addr;
            end
            TK_LIST:
            begin
                slot_raddr = list_rdata;
            end
            TK_SLOT:
            begin
                if (expire)
                begin
                    list_raddr = tail_addr;
                end
                else
                begin
                    slot_we    = 1'b1;
                    slot_wdata = {rd_pos, life_dec};
                    list_raddr = idx_p1[AW-1:0];
                end
            end
            TK_LAST:
            begin
                slot_raddr = list_rdata;
            end
            TK_MOVE:
            begin
                slot_we    = 1'b1;
                slot_waddr = last_reg;
                slot_wdata = {idx_reg, rd_life};
                list_we    = 1'b1;
                list_waddr = idx_reg;
                list_wdata = last_reg;
            end
            TK_NEXT:
            begin
                list_raddr = idx_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= IDLE;
            count_reg    <= '0;
            start_reg    <= '0;
            cur_reg      <= '0;
            last_reg     <= '0;
            idx_reg      <= '0;
            expired_reg  <= '0;
            life_reg     <= '0;
            elapsed_reg  <= '0;
            slot_out_reg <= '0;
            evict_reg    <= 1'b0;
        end
        else
        begin
            case (state_reg)
                IDLE:
                begin
                    if (cmd_valid)
                    begin
                        life_reg     <= life_sat;
                        elapsed_reg  <= cmd.elapsed_ticks;
                        slot_out_reg <= '0;
                        evict_reg    <= 1'b0;
                        expired_reg  <= '0;
                        idx_reg      <= '0;
                        cur_reg      <= start_reg;
                        case (cmd.command)
                            CMD_SPAWN:
                            begin
                                state_reg <= (count_reg == FULL) ? EV_HEAD : SC_POS;
                            end
                            CMD_TICK:
                            begin
                                state_reg <= (count_reg == '0) ? DONE : TK_LIST;
                            end
                            CMD_CLEAR:
                            begin
                                count_reg <= '0;
                                state_reg <= DONE;
                            end
                            default:
                            begin
                                state_reg <= DONE;
                            end
                        endcase
                    end
                end
                SC_POS:
                begin
                    if (pos_free)
                    begin
                        count_reg    <= count_reg + 1'b1;
                        start_reg    <= cur_succ;
                        slot_out_reg <= cur_reg;
                        state_reg    <= DONE;
                    end
                    else
                    begin
                        state_reg <= SC_LIST;
                    end
                end
                SC_LIST:
                begin
                    if (list_hit)
                    begin
                        cur_reg   <= cur_succ;
                        state_reg <= SC_POS;
                    end
                    else
                    begin
                        count_reg    <= count_reg + 1'b1;
                        start_reg    <= cur_succ;
                        slot_out_reg <= cur_reg;
                        state_reg    <= DONE;
                    end
                end
                EV_HEAD:
                begin
                    cur_reg   <= list_rdata;
                    state_reg <= EV_LAST;
                end
                EV_LAST:
                begin
                    last_reg  <= list_rdata;
                    state_reg <= EV_RMW;
                end
                EV_RMW:
                begin
                    state_reg <= EV_APP;
                end
                EV_APP:
                begin
                    slot_out_reg <= cur_reg;
                    evict_reg    <= 1'b1;
                    start_reg    <= cur_succ;
                    state_reg    <= DONE;
                end
                TK_LIST:
                begin
                    cur_reg   <= list_rdata;
                    state_reg <= TK_SLOT;
                end
                TK_SLOT:
                begin
                    if (expire)
                    begin
                        expired_reg <= expired_reg + 1'b1;
                        if (idx_p1 == count_reg)
                        begin
                            count_reg <= count_m1;
                            state_reg <= DONE;
                        end
                        else
                        begin
                            state_reg <= TK_LAST;
                        end
                    end
                    else
                    begin
                        idx_reg   <= idx_p1[AW-1:0];
                        state_reg <= (idx_p1 < count_reg) ? TK_LIST : DONE;
                    end
                end
                TK_LAST:
                begin
                    last_reg  <= list_rdata;
                    state_reg <= TK_MOVE;
                end
                TK_MOVE:
                begin
                    count_reg <= count_m1;
                    state_reg <= TK_NEXT;
                end
                TK_NEXT:
                begin
                    state_reg <= TK_LIST;
                end
                DONE:
                begin
                    if (res_ready)
                    begin
                        state_reg <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[src/lifetime_slot_pool.sv]
// A clear zeroes the active count. A spawn probes slots from the search start until it
// finds a free one, or on a full pool evicts the list head and reuses its slot as the
// new tail. A tick walks the active list, writing back surviving lives and moving the
// list tail into each expired entry's place. One command is worked at a time, each list
// step costing a list read, a dependent slot read and a write-back on 1R1W memories.
// Reset clears the active count, search start and other registers; memories are not swept.
`default_nettype none

module lifetime_slot_pool
    import lsp_pkg::*;
#(
    parameter int SLOTS     = 64,
    parameter int LIFE_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // life_ticks [15:0], elapsed_ticks [31:16]
    input  wire logic [1:0]  s_tuser,   // command [1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // slot_index [5:0], evicted [6],
                                        // expired_count [13:7], active_total [20:14],
                                        // zero [23:21]
);

    localparam int AW = $clog2(SLOTS);
    localparam int SW = AW + LIFE_BITS;

    // The pool state lives in two memories. The slot memory holds, per slot, the slot's
    // position in the active list and its remaining life. The list memory holds the dense
    // active list. A slot counts as active when its stored position is below the active
    // count and the list entry there names the slot again, so a clear only zeroes the count.
    logic          slot_we;
    logic [AW-1:0] slot_waddr;
    logic [SW-1:0] slot_wdata;
    logic [AW-1:0] slot_raddr;
    logic [SW-1:0] slot_rdata;
    logic          list_we;
    logic [AW-1:0] list_waddr;
    logic [AW-1:0] list_wdata;
    logic [AW-1:0] list_raddr;
    logic [AW-1:0] list_rdata;

    lsp_cmd_t cmd;
    lsp_res_t res;
    logic     res_valid;
    logic     res_ready;

    logic        m_valid_reg;
    logic [23:0] m_data_reg;

    assign cmd.command       = s_tuser;
    assign cmd.life_ticks    = s_tdata[15:0];
    assign cmd.elapsed_ticks = s_tdata[31:16];

    lsp_ram #(
        .WIDTH (SW),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    lsp_ram #(
        .WIDTH (AW),
        .DEPTH (SLOTS)
    ) u_list_ram (
        .clk   (clk),
        .we    (list_we),
        .waddr (list_waddr),
        .wdata (list_wdata),
        .raddr (list_raddr),
        .rdata (list_rdata)
    );

    lsp_seq #(
        .SLOTS     (SLOTS),
        .LIFE_BITS (LIFE_BITS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (s_tvalid),
        .cmd_ready  (s_tready),
        .cmd        (cmd),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .slot_we    (slot_we),
        .slot_waddr (slot_waddr),
        .slot_wdata (slot_wdata),
        .slot_raddr (slot_raddr),
        .slot_rdata (slot_rdata),
        .list_we    (list_we),
        .list_waddr (list_waddr),
        .list_wdata (list_wdata),
        .list_raddr (list_raddr),
        .list_rdata (list_rdata)
    );

    // The output register decouples the sequencer from the consumer: once a result is
    // parked here the sequencer returns to idle and takes the next command while this
    // transfer still waits on m_tready.
    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                m_valid_reg <= 1'b1;
                m_data_reg  <= {3'b000, res.active_total, res.expired_count,
                                res.evicted, res.slot_index};
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // An eviction only happens on a full pool, and the pool stays full afterward.
    a_evict_full : assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.evicted |-> res.active_total == COUNT_OUT_W'(SLOTS))
        else $error("eviction reported with a pool that is not full");

    // Expirations come from ticks alone, which give no slot and evict nothing.
    a_tick_only : assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.expired_count != '0 |-> !res.evicted && res.slot_index == '0)
        else $error("expired count reported together with spawn fields");

    // Commands are worked one at a time: the input closes after each accepted transfer.
    a_one_at_a_time : assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a command is in progress");

endmodule

`default_nettype wire
